>>> src/brbp_pkg.sv
`default_nettype none

package brbp_pkg;

	localparam int SAMPLE_BITS       = 24;
	localparam int COLUMN_BITS       = 6;
	localparam int FRACTION_BITS_DEF = 16;

	// Marker window: upper COLUMN_BITS of the SAMPLE_BITS-wide position
	localparam int POS_SHIFT = (SAMPLE_BITS > COLUMN_BITS) ? SAMPLE_BITS - COLUMN_BITS : 1;

	localparam int GAIN_BITS   = 5;
	localparam int WEIGHT_BITS = 16;

	localparam logic [GAIN_BITS-1:0]   GAIN_RESET   = '0;
	localparam logic [WEIGHT_BITS-1:0] WEIGHT_RESET = 16'd655;

	localparam int CFG_INDEX_BITS = 2;
	localparam int CFG_DATA_BITS  = WEIGHT_BITS;

	localparam logic [CFG_INDEX_BITS-1:0] REG_GAIN_SHIFT       = 2'd0;
	localparam logic [CFG_INDEX_BITS-1:0] REG_SMOOTHING_WEIGHT = 2'd1;

	localparam logic CMD_SAMPLE = 1'b0;
	localparam logic CMD_TICK   = 1'b1;

	typedef struct packed {
		logic                   cmd;
		logic [SAMPLE_BITS-1:0] sample;
	} in_item_t;

	typedef struct packed {
		logic [COLUMN_BITS-1:0] column;
		logic                   below;
		logic                   above;
		logic                   tick_mark;
	} out_item_t;

endpackage

`default_nettype wire

>>> src/baseline_removed_bar_position.sv
// Baseline-removed bar position. Each sample item pulls an exponential
// baseline (Q.FRACTION_BITS fixed point) toward the reading by the smoothing
// weight, subtracts the new baseline's integer part, scales by 2^gain_shift
// and maps the result onto a bar of 2^COLUMN_BITS columns with below/above
// flags. Tick items produce no result; they set a mark carried by the next
// result. One item is taken every cycle unless in_stall holds it; a sample's
// result is registered in turn by the input register, the baseline update with
// its 40x16 multiply and the position mapping into the output register. The rate
// is bound by the baseline feedback loop, which closes through the baseline register alone.
// Configuration must only be written while the block is empty.
`default_nettype none

module baseline_removed_bar_position import brbp_pkg::*; #(
	parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      in_valid,
	output logic                           in_stall,
	input  wire in_item_t                  in_data,
	output logic                           out_valid,
	input  wire logic                      out_stall,
	output out_item_t                      out_data,
	input  wire logic                      cfg_wr_en,
	input  wire logic [CFG_INDEX_BITS-1:0] cfg_index,
	input  wire logic [CFG_DATA_BITS-1:0]  cfg_data
);

	// configuration registers
	logic [GAIN_BITS-1:0]   gain_q;
	logic [WEIGHT_BITS-1:0] weight_q;

	// stage 1: input register
	logic                   valid_s1;
	logic                   cmd_s1;
	logic [SAMPLE_BITS-1:0] sample_s1;

	// stage 2: sample and updated baseline
	logic                   valid_s2;
	logic [SAMPLE_BITS-1:0] sample_s2;
	logic [SAMPLE_BITS-1:0] base_s2;
	logic                   tick_s2;

	// result register
	logic      out_valid_q;
	out_item_t out_data_q;

	logic tick_pending_q;

	logic                   ready_out;
	logic                   ready_s2;
	logic                   move_s1;
	logic [SAMPLE_BITS-1:0] base_int;
	out_item_t              result;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q   <= GAIN_RESET;
			weight_q <= WEIGHT_RESET;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_GAIN_SHIFT:       gain_q   <= cfg_data[GAIN_BITS-1:0];
				REG_SMOOTHING_WEIGHT: weight_q <= cfg_data[WEIGHT_BITS-1:0];
				default: ;
			endcase
		end
	end

	// Ticks leave stage 1 at once; only samples wait on the stages below.
	assign ready_out = !out_valid_q || !out_stall;
	assign ready_s2  = !valid_s2 || ready_out;
	assign move_s1   = valid_s1 && (cmd_s1 == CMD_SAMPLE) && ready_s2;
	assign in_stall  = valid_s1 && (cmd_s1 == CMD_SAMPLE) && !ready_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			cmd_s1    <= in_data.cmd;
			sample_s1 <= in_data.sample;
		end
	end

	// Set the mark on a tick; hand it to the next sample and clear it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_pending_q <= 1'b0;
		end else if (valid_s1 && (cmd_s1 == CMD_TICK)) begin
			tick_pending_q <= 1'b1;
		end else if (move_s1) begin
			tick_pending_q <= 1'b0;
		end
	end

	brbp_baseline #(
		.FRACTION_BITS(FRACTION_BITS)
	) u_baseline (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (move_s1),
		.sample  (sample_s1),
		.weight  (weight_q),
		.base_int(base_int)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (ready_s2) begin
			valid_s2 <= move_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (move_s1) begin
			sample_s2 <= sample_s1;
			base_s2   <= base_int;
			tick_s2   <= tick_pending_q;
		end
	end

	brbp_position u_position (
		.sample  (sample_s2),
		.base_int(base_s2),
		.gain    (gain_q),
		.column  (result.column),
		.below   (result.below),
		.above   (result.above)
	);

	assign result.tick_mark = tick_s2;

	// Hold the result while the far side stalls.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ready_out) begin
			out_valid_q <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_out && valid_s2) begin
			out_data_q <= result;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule

`default_nettype wire

>>> src/brbp_baseline.sv
`default_nettype none

module brbp_baseline import brbp_pkg::*; #(
	parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   advance,
	input  wire logic [SAMPLE_BITS-1:0] sample,
	input  wire logic [WEIGHT_BITS-1:0] weight,
	output logic      [SAMPLE_BITS-1:0] base_int
);

	localparam int BW = SAMPLE_BITS + FRACTION_BITS;
	localparam int PW = BW + WEIGHT_BITS;

	localparam logic [BW-1:0] BASE_RESET = BW'(1) << (BW - 1);
	localparam logic [PW-1:0] ROUND_UP   = PW'({WEIGHT_BITS{1'b1}});

	logic [BW-1:0] baseline_q;
	logic [BW-1:0] target;
	logic [BW-1:0] gap;
	logic [PW-1:0] prod;
	logic [PW-1:0] prod_up;
	logic [BW-1:0] base_next;
	logic          rising;

	always_comb begin
		target  = {sample, {FRACTION_BITS{1'b0}}};
		rising  = (target >= baseline_q);
		gap     = rising ? (target - baseline_q) : (baseline_q - target);
		prod    = PW'(gap) * PW'(weight);
		prod_up = prod + ROUND_UP;
		// floor the step when rising, ceil it when falling
		if (rising) begin
			base_next = baseline_q + prod[PW-1:WEIGHT_BITS];
		end else begin
			base_next = baseline_q - prod_up[PW-1:WEIGHT_BITS];
		end
		base_int = base_next[BW-1:FRACTION_BITS];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			baseline_q <= BASE_RESET;
		end else if (advance) begin
			baseline_q <= base_next;
		end
	end

endmodule

`default_nettype wire

>>> src/brbp_position.sv
`default_nettype none

module brbp_position import brbp_pkg::*; (
	input  wire logic [SAMPLE_BITS-1:0] sample,
	input  wire logic [SAMPLE_BITS-1:0] base_int,
	input  wire logic [GAIN_BITS-1:0]   gain,
	output logic      [COLUMN_BITS-1:0] column,
	output logic                        below,
	output logic                        above
);

	localparam int D_W   = SAMPLE_BITS + 1;
	localparam int SH_W  = D_W + (1 << GAIN_BITS) - 1;
	localparam int LIM_B = 48;
	localparam int R_W   = LIM_B + 3;
	localparam int TOP   = POS_SHIFT + COLUMN_BITS;

	localparam logic [SH_W-1:0] SCALE_LIMIT = SH_W'(1) << LIM_B;
	localparam logic signed [R_W-1:0] POS_OFFSET =
		R_W'((64'd1 << (SAMPLE_BITS - 1)) + (64'd1 << (POS_SHIFT - 1)));

	logic signed [D_W-1:0]  diff;
	logic        [D_W-1:0]  mag;
	logic        [SH_W-1:0] shifted;
	logic        [SH_W-1:0] clamped;
	logic signed [R_W-1:0]  s_mag;
	logic signed [R_W-1:0]  scaled;
	logic signed [R_W-1:0]  pos;
	logic                   neg;
	logic                   high_any;
	logic [COLUMN_BITS-1:0] win;

	always_comb begin
		diff    = $signed({1'b0, sample}) - $signed({1'b0, base_int});
		mag     = diff[D_W-1] ? D_W'(-diff) : D_W'(diff);
		shifted = SH_W'(mag) << gain;
		// saturate far outside the display; flags stay exact
		clamped = (shifted > SCALE_LIMIT) ? SCALE_LIMIT : shifted;
		s_mag   = $signed(R_W'(clamped));
		scaled  = diff[D_W-1] ? -s_mag : s_mag;
		pos     = scaled + POS_OFFSET;

		neg      = pos[R_W-1];
		high_any = |pos[R_W-2:TOP];
		win      = pos[TOP-1:POS_SHIFT];

		below  = neg || (!high_any && (win == '0));
		above  = !neg && high_any;
		column = (below || above) ? '0 : win;
	end

endmodule

`default_nettype wire

>>> test/brbp_bar_monitor.sv
module brbp_bar_monitor import brbp_pkg::*; #(
	parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	input  logic                      in_stall,
	input  in_item_t                  in_data,
	input  logic                      out_valid,
	input  logic                      out_stall,
	input  out_item_t                 out_data,
	input  logic                      cfg_wr_en,
	input  logic [CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [CFG_DATA_BITS-1:0]  cfg_data,
	output int                        pending,
	output int                        mismatch_count
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam longint SCALE_LIMIT = 64'sd1 << 48;
	localparam longint COLUMNS     = 64'sd1 << COLUMN_BITS;
	localparam longint POS_OFFSET  = (64'sd1 << (SAMPLE_BITS - 1)) + (64'sd1 << (POS_SHIFT - 1));

	logic [63:0]          baseline_q;
	logic                 tick_q;
	logic [GAIN_BITS-1:0] gain_q;
	logic [63:0]          weight_q;
	out_item_t            expected_bars[$];
	out_item_t            oldest_bar;

	// Pull the baseline toward the reading, then map the difference onto the bar.
	function automatic out_item_t predict_bar(input logic [SAMPLE_BITS-1:0] smp);
		logic [63:0] target;
		logic [63:0] gap;
		logic [63:0] step;
		longint      diff;
		longint      mag;
		longint      scaled;
		longint      pos_r;
		longint      pos;
		out_item_t   res;
		target = 64'(smp) << FRACTION_BITS;
		if (target >= baseline_q) begin
			gap        = target - baseline_q;
			step       = (gap >> 16) * weight_q + (((gap & 64'hffff) * weight_q) >> 16);
			baseline_q = baseline_q + step;
		end else begin
			gap        = baseline_q - target;
			step       = (gap >> 16) * weight_q + (((gap & 64'hffff) * weight_q + 64'hffff) >> 16);
			baseline_q = baseline_q - step;
		end
		diff = longint'(smp) - longint'(baseline_q >> FRACTION_BITS);
		mag  = (diff < 0) ? -diff : diff;
		if (gain_q >= 48 || mag > (SCALE_LIMIT >>> gain_q))
			mag = SCALE_LIMIT;
		else
			mag = mag << gain_q;
		scaled = (diff < 0) ? -mag : mag;
		pos_r  = scaled + POS_OFFSET;
		pos    = (pos_r < 0) ? 64'sd0 : (pos_r >>> POS_SHIFT);
		res = '0;
		if (pos <= 0)
			res.below = 1'b1;
		else if (pos >= COLUMNS)
			res.above = 1'b1;
		else
			res.column = pos[COLUMN_BITS-1:0];
		res.tick_mark = tick_q;
		tick_q = 1'b0;
		return res;
	endfunction

	task automatic check_field(input string name, input int want, input int got);
		if (want != got) begin
			mismatch_count++;
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			baseline_q = 64'(1) << (SAMPLE_BITS - 1 + FRACTION_BITS);
			tick_q     = 1'b0;
			gain_q     = GAIN_RESET;
			weight_q   = 64'(WEIGHT_RESET);
			expected_bars.delete();
			mismatch_count = 0;
			pending        = 0;
		end else begin
			if (cfg_wr_en) begin
				case (cfg_index)
					REG_GAIN_SHIFT:       gain_q   = cfg_data[GAIN_BITS-1:0];
					REG_SMOOTHING_WEIGHT: weight_q = 64'(cfg_data);
					default: ;
				endcase
			end
			// Results leave only after their item has been registered through the pipeline, so compare first.
			if (out_valid && !out_stall) begin
				if (expected_bars.size() == 0) begin
					mismatch_count++;
					$display("%0t: unexpected result, expected none, actual %h", $time, out_data);
				end else begin
					oldest_bar = expected_bars.pop_front();
					check_field("column", oldest_bar.column, out_data.column);
					check_field("below", oldest_bar.below, out_data.below);
					check_field("above", oldest_bar.above, out_data.above);
					check_field("tick_mark", oldest_bar.tick_mark, out_data.tick_mark);
				end
			end
			if (in_valid && !in_stall) begin
				if (in_data.cmd == CMD_TICK)
					tick_q = 1'b1;
				else
					expected_bars.push_back(predict_bar(in_data.sample));
			end
			pending = expected_bars.size();
		end
	end

endmodule

>>> test/baseline_removed_bar_position_tb.sv
module baseline_removed_bar_position_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import brbp_pkg::*;

	// Run length: roughly 1850 random items spread across eight register settings
	localparam int RANDOM_ITEMS = 1850;
	localparam int PHASES       = 8;
	// Quiet cycles after the last result: three-stage pipeline plus margin
	localparam int SETTLE       = 8;
	localparam int CYCLE_LIMIT  = 400000;
	localparam int IN_ITEM_BITS = $bits(in_item_t);

	logic                      clk       = 1'b0;
	logic                      arst_n    = 1'b0;
	logic                      in_valid  = 1'b0;
	logic                      in_stall;
	in_item_t                  in_data   = '0;
	logic                      out_valid;
	logic                      out_stall = 1'b0;
	out_item_t                 out_data;
	logic                      cfg_wr_en = 1'b0;
	logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
	logic [CFG_DATA_BITS-1:0]  cfg_data  = '0;

	int                        pending;
	int                        mismatch_count;
	int                        cycle_count = 0;
	logic [SAMPLE_BITS-1:0]    centre = 24'h800000;

	baseline_removed_bar_position u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// Watch both channels and the register port, predict and compare
	brbp_bar_monitor u_monitor (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.in_data        (in_data),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.out_data       (out_data),
		.cfg_wr_en      (cfg_wr_en),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.pending        (pending),
		.mismatch_count (mismatch_count)
	);

	// 10 ns clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Watchdog: give up well beyond the slowest legitimate run
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	// Receiver back-pressure: pick a mode and hold it for a random run of cycles.
	// Modes: never stall, light stalls, heavy stalls, almost always stalled.
	always @(negedge clk) begin
		static int stall_mode = 0;
		static int stall_run  = 0;
		if (stall_run == 0) begin
			stall_mode = $urandom_range(0, 3);
			stall_run  = $urandom_range(4, 60);
		end else begin
			stall_run--;
		end
		case (stall_mode)
			0:       out_stall <= 1'b0;
			1:       out_stall <= ($urandom_range(0, 3) == 0);
			2:       out_stall <= ($urandom_range(0, 1) == 1);
			default: out_stall <= ($urandom_range(0, 7) != 0);
		endcase
	end

	function automatic in_item_t make_item(input logic cmd, input logic [SAMPLE_BITS-1:0] value);
		in_item_t item;
		item.cmd    = cmd;
		item.sample = value;
		return item;
	endfunction

	// Mix of ticks, full-range readings, extremes and readings near the phase centre.
	// The near-centre readings lie within 2^22 of the phase centre, clipped to the sample range.
	function automatic in_item_t random_item();
		int     k;
		longint v;
		case ($urandom_range(0, 19))
			0, 1, 2: return make_item(CMD_TICK, SAMPLE_BITS'($urandom()));
			3, 4, 5, 6, 7: return make_item(CMD_SAMPLE, SAMPLE_BITS'($urandom()));
			8: begin
				case ($urandom_range(0, 3))
					0:       v = 0;
					1:       v = 24'hffffff;
					2:       v = 24'h800000;
					default: v = 24'h7fffff;
				endcase
				return make_item(CMD_SAMPLE, SAMPLE_BITS'(v));
			end
			default: begin
				k = $urandom_range(0, 22);
				v = longint'($urandom_range(0, 1 << k));
				v = $urandom_range(0, 1) ? longint'(centre) + v : longint'(centre) - v;
				if (v < 0)
					v = 0;
				if (v > 24'hffffff)
					v = 24'hffffff;
				return make_item(CMD_SAMPLE, SAMPLE_BITS'(v));
			end
		endcase
	endfunction

	// Present an item at the falling edge and hold it until a rising edge takes it
	task automatic send_item(input in_item_t item);
		@(negedge clk);
		in_valid <= 1'b1;
		in_data  <= item;
		do @(posedge clk); while (in_stall);
	endtask

	// Drop valid; scribble on the data to show it is ignored
	task automatic pause_sender(input int n);
		@(negedge clk);
		in_valid <= 1'b0;
		in_data  <= in_item_t'(IN_ITEM_BITS'($urandom()));
		repeat (n - 1) @(negedge clk);
	endtask

	// Wait for every expected result, then let the pipeline empty of trailing ticks
	task automatic drain();
		pause_sender(1);
		while (pending != 0)
			@(negedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
	                         input logic [CFG_DATA_BITS-1:0] value);
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	// Registers change only with the block empty
	task automatic set_phase(input int gain, input int weight);
		drain();
		write_reg(REG_GAIN_SHIFT, CFG_DATA_BITS'(gain));
		write_reg(REG_SMOOTHING_WEIGHT, CFG_DATA_BITS'(weight));
	endtask

	initial begin
		int burst_left;
		int gap;
		burst_left = 0;

		// Hold reset, then release it on a falling edge
		repeat (11) @(negedge clk);
		arst_n <= 1'b1;

		// Directed items at the reset settings: centre, both rails, tick marks
		// (single and doubled), and readings just either side of the centre
		send_item(make_item(CMD_SAMPLE, 24'h800000));
		send_item(make_item(CMD_SAMPLE, 24'h000000));
		send_item(make_item(CMD_SAMPLE, 24'hffffff));
		send_item(make_item(CMD_TICK, 24'h000000));
		send_item(make_item(CMD_SAMPLE, 24'h800000));
		send_item(make_item(CMD_TICK, 24'hffffff));
		send_item(make_item(CMD_TICK, 24'h5a5a5a));
		send_item(make_item(CMD_SAMPLE, 24'h7fffff));
		send_item(make_item(CMD_SAMPLE, 24'h840000));
		send_item(make_item(CMD_SAMPLE, 24'h7c0000));

		// Gain 23 and maximum weight: baseline snaps to the reading; big swings
		// push the position far negative or far past the last column
		set_phase(23, 65535);
		send_item(make_item(CMD_SAMPLE, 24'h800000));
		send_item(make_item(CMD_SAMPLE, 24'h000000));
		send_item(make_item(CMD_SAMPLE, 24'hffffff));
		send_item(make_item(CMD_TICK, 24'h123456));
		send_item(make_item(CMD_SAMPLE, 24'h800001));
		send_item(make_item(CMD_SAMPLE, 24'h000000));

		// Random phases: gain 0 or 23 with weight 1 or 65535 first, a frozen baseline
		// (zero weight), then random settings
		for (int ph = 0; ph < PHASES; ph++) begin
			case (ph)
				0:       set_phase(0, 1);
				1:       set_phase(23, 65535);
				2:       set_phase(0, 65535);
				3:       set_phase(23, 1);
				4:       set_phase($urandom_range(0, 23), 0);
				default: set_phase($urandom_range(0, 23), $urandom_range(1, 65535));
			endcase
			centre = $urandom_range(0, 1) ? 24'h800000 : SAMPLE_BITS'($urandom());
			for (int i = 0; i < RANDOM_ITEMS / PHASES; i++) begin
				// Bursts of random length; some gaps are zero to give unbroken stretches
				if (burst_left == 0) begin
					burst_left = $urandom_range(1, 40);
					gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
					if (gap > 0)
						pause_sender(gap);
				end
				burst_left--;
				// Now and then stop until the block has handed back everything
				if ($urandom_range(0, 399) == 0)
					drain();
				send_item(random_item());
			end
		end

		drain();
		if (mismatch_count == 0 && pending == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
